/* rtl/core/sdtl_pkg.sv */
`timescale 1ns / 1ps

package sdtl_pkg;

   // Request kinds carried on req_tuser
   localparam logic [1:0] OP_START  = 2'd0;
   localparam logic [1:0] OP_STOP   = 2'd1;
   localparam logic [1:0] OP_EXPIRE = 2'd2;

   // Alarm update codes
   localparam logic [1:0] ACT_NONE    = 2'd0;
   localparam logic [1:0] ACT_ARMED   = 2'd1;
   localparam logic [1:0] ACT_STOPPED = 2'd2;

   // Packed widths of the stream payloads
   localparam int ReqDataW = 104;
   localparam int RspDataW = 40;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_UL_NEXT,
      ST_UL_ALARM,
      ST_UL_WALK,
      ST_INS_START,
      ST_INS_WALK,
      ST_INS_LINK,
      ST_INS_PREV,
      ST_PROC,
      ST_DONE
   } state_type;

   // a fires before b on the wrapping 32-bit time line
   function automatic logic wrap_before(input logic [31:0] a, input logic [31:0] b);
      logic [31:0] diff;
      diff = a - b;
      return diff[31];
   endfunction

   // Time left until fire time ft, zero once it has passed
   function automatic logic [31:0] time_left(input logic [31:0] ft, input logic [31:0] now);
      logic [31:0] ahead;
      ahead = ft - now;
      return wrap_before(now, ft) ? ahead : 32'd0;
   endfunction

endpackage

/* rtl/core/sorted_deadline_timer_list.sv */
`timescale 1ns / 1ps

// Channel  | Dir | Handshake             | Payload
// request  | in  | req_tvalid/req_tready | req_tuser: op; req_tdata: timer_id, now,
//          |     |                       |   start_time, delay
// response | out | rsp_tvalid/rsp_tready | rsp_tdata: fired, fired_id, alarm_action,
//          |     |                       |   alarm_remaining
//
// One request at a time. A stop or a start may walk the list, which reads one link from
// the link memory per cycle; an expiry check looks only at the head and does not walk.
// Synchronous reset empties the list and clears the linked bits; the memories need
// no clearing pass. A stalled response sits in its output register while the next
// request is taken; only the final load of a later response waits for it.

module sorted_deadline_timer_list #(
   parameter int NUM_TIMERS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [1:0]                    req_tuser,  // op
   // timer_id[3:0], now[35:4], start_time[67:36], delay[98:68], zero fill
   input  logic [sdtl_pkg::ReqDataW-1:0] req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // fired[0], fired_id[4:1], alarm_action[6:5], alarm_remaining[38:7], zero fill
   output logic [sdtl_pkg::RspDataW-1:0] rsp_tdata
);

   localparam int SlotW = $clog2(NUM_TIMERS + 1);
   localparam int AddrW = $clog2(NUM_TIMERS);
   localparam logic [SlotW-1:0] SlotEnd = SlotW'(NUM_TIMERS);

   // Control state
   sdtl_pkg::state_type     state_ff, state_in;
   logic [SlotW-1:0]        head_ff, head_in;
   logic [NUM_TIMERS-1:0]   linked_ff, linked_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   // Request and walk registers
   logic [1:0]              op_ff, op_in;
   logic [3:0]              id_ff, id_in;
   logic [SlotW-1:0]        slot_ff, slot_in;
   logic [31:0]             now_ff, now_in;
   logic [31:0]             start_ff, start_in;
   logic [30:0]             delay_ff, delay_in;
   logic [31:0]             fnew_ff, fnew_in;
   logic                    apast_ff, apast_in;
   logic [SlotW-1:0]        cur_ff, cur_in;
   logic [SlotW-1:0]        prev_ff, prev_in;
   logic [SlotW-1:0]        ns_ff, ns_in;
   logic                    fired_ff, fired_in;
   logic [3:0]              fid_ff, fid_in;
   logic [1:0]              act_ff, act_in;
   logic [31:0]             rem_ff, rem_in;
   logic [sdtl_pkg::RspDataW-1:0] rsp_data_ff, rsp_data_in;

   // Memories and their ports
   logic [31:0]             fire_mem [NUM_TIMERS];
   logic [SlotW-1:0]        next_mem [NUM_TIMERS];
   logic [31:0]             fire_rd_ff;
   logic [SlotW-1:0]        next_rd_ff;
   logic [AddrW-1:0]        rd_addr;
   logic                    fire_we;
   logic [AddrW-1:0]        fire_wa;
   logic [31:0]             fire_wd;
   logic                    next_we;
   logic [AddrW-1:0]        next_wa;
   logic [SlotW-1:0]        next_wd;

   logic                    id_ok;
   logic                    b_past;
   logic                    goes_first;
   sdtl_pkg::state_type     after_unlink;

   assign req_tready = (state_ff == sdtl_pkg::ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign id_ok = ({4'b0000, id_ff} < 8'(NUM_TIMERS));
   assign after_unlink = (op_ff == sdtl_pkg::OP_START) ? sdtl_pkg::ST_INS_START
                                                        : sdtl_pkg::ST_DONE;

   // Wrap-aware order of the new fire time against the entry under the walk
   assign b_past     = sdtl_pkg::wrap_before(fire_rd_ff, now_ff);
   assign goes_first = (b_past != apast_ff) ? apast_ff
                                            : sdtl_pkg::wrap_before(fnew_ff, fire_rd_ff);

   // Fire time and link memories, one write and one registered read each
   always_ff @(posedge clock) begin
      if (fire_we) begin
         fire_mem[fire_wa] <= fire_wd;
      end
      fire_rd_ff <= fire_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (next_we) begin
         next_mem[next_wa] <= next_wd;
      end
      next_rd_ff <= next_mem[rd_addr];
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sdtl_pkg::ST_IDLE;
         head_ff      <= SlotEnd;
         linked_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         linked_ff    <= linked_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      id_ff       <= id_in;
      slot_ff     <= slot_in;
      now_ff      <= now_in;
      start_ff    <= start_in;
      delay_ff    <= delay_in;
      fnew_ff     <= fnew_in;
      apast_ff    <= apast_in;
      cur_ff      <= cur_in;
      prev_ff     <= prev_in;
      ns_ff       <= ns_in;
      fired_ff    <= fired_in;
      fid_ff      <= fid_in;
      act_ff      <= act_in;
      rem_ff      <= rem_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Sequencer: next state, walk control and memory ports
   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      linked_in    = linked_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      op_in        = op_ff;
      id_in        = id_ff;
      slot_in      = slot_ff;
      now_in       = now_ff;
      start_in     = start_ff;
      delay_in     = delay_ff;
      fnew_in      = fnew_ff;
      apast_in     = apast_ff;
      cur_in       = cur_ff;
      prev_in      = prev_ff;
      ns_in        = ns_ff;
      fired_in     = fired_ff;
      fid_in       = fid_ff;
      act_in       = act_ff;
      rem_in       = rem_ff;
      rsp_data_in  = rsp_data_ff;
      rd_addr      = '0;
      fire_we      = 1'b0;
      fire_wa      = slot_ff[AddrW-1:0];
      fire_wd      = start_ff + {1'b0, delay_ff};
      next_we      = 1'b0;
      next_wa      = slot_ff[AddrW-1:0];
      next_wd      = cur_ff;

      unique case (state_ff)
         // Take a request and clear the result
         sdtl_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               op_in    = req_tuser;
               id_in    = req_tdata[3:0];
               slot_in  = SlotW'(req_tdata[3:0]);
               now_in   = req_tdata[35:4];
               start_in = req_tdata[67:36];
               delay_in = req_tdata[98:68];
               fired_in = 1'b0;
               fid_in   = 4'd0;
               act_in   = sdtl_pkg::ACT_NONE;
               rem_in   = 32'd0;
               state_in = sdtl_pkg::ST_DECODE;
            end
         end

         sdtl_pkg::ST_DECODE: begin
            rd_addr = slot_ff[AddrW-1:0];
            if (op_ff == sdtl_pkg::OP_START && id_ok) begin
               fire_we = 1'b1;
               fnew_in = fire_wd;
               state_in = linked_ff[slot_ff[AddrW-1:0]] ? sdtl_pkg::ST_UL_NEXT
                                                        : sdtl_pkg::ST_INS_START;
            end else if (op_ff == sdtl_pkg::OP_STOP && id_ok) begin
               state_in = linked_ff[slot_ff[AddrW-1:0]] ? sdtl_pkg::ST_UL_NEXT
                                                        : sdtl_pkg::ST_DONE;
            end else if (op_ff == sdtl_pkg::OP_EXPIRE) begin
               if (head_ff == SlotEnd) begin
                  act_in   = sdtl_pkg::ACT_STOPPED;
                  state_in = sdtl_pkg::ST_DONE;
               end else begin
                  rd_addr  = head_ff[AddrW-1:0];
                  state_in = sdtl_pkg::ST_PROC;
               end
            end else begin
               state_in = sdtl_pkg::ST_DONE;
            end
         end

         // Head fire time is out: fire it or re-arm the alarm
         sdtl_pkg::ST_PROC: begin
            if (!sdtl_pkg::wrap_before(now_ff, fire_rd_ff)) begin
               fired_in = 1'b1;
               fid_in   = 4'(head_ff);
               slot_in  = head_ff;
               rd_addr  = head_ff[AddrW-1:0];
               state_in = sdtl_pkg::ST_UL_NEXT;
            end else begin
               act_in   = sdtl_pkg::ACT_ARMED;
               rem_in   = sdtl_pkg::time_left(fire_rd_ff, now_ff);
               state_in = sdtl_pkg::ST_DONE;
            end
         end

         // Successor of the slot is out: drop it from the head or start the walk
         sdtl_pkg::ST_UL_NEXT: begin
            ns_in = next_rd_ff;
            if (head_ff == slot_ff) begin
               head_in = next_rd_ff;
               linked_in[slot_ff[AddrW-1:0]] = 1'b0;
               if (next_rd_ff == SlotEnd) begin
                  act_in   = sdtl_pkg::ACT_STOPPED;
                  rem_in   = 32'd0;
                  state_in = after_unlink;
               end else begin
                  rd_addr  = next_rd_ff[AddrW-1:0];
                  state_in = sdtl_pkg::ST_UL_ALARM;
               end
            end else begin
               cur_in   = head_ff;
               rd_addr  = head_ff[AddrW-1:0];
               state_in = sdtl_pkg::ST_UL_WALK;
            end
         end

         sdtl_pkg::ST_UL_ALARM: begin
            act_in   = sdtl_pkg::ACT_ARMED;
            rem_in   = sdtl_pkg::time_left(fire_rd_ff, now_ff);
            state_in = after_unlink;
         end

         // Find the predecessor and bridge over the slot
         sdtl_pkg::ST_UL_WALK: begin
            if (next_rd_ff == slot_ff) begin
               next_we  = 1'b1;
               next_wa  = cur_ff[AddrW-1:0];
               next_wd  = ns_ff;
               linked_in[slot_ff[AddrW-1:0]] = 1'b0;
               state_in = after_unlink;
            end else begin
               cur_in  = next_rd_ff;
               rd_addr = next_rd_ff[AddrW-1:0];
            end
         end

         sdtl_pkg::ST_INS_START: begin
            apast_in = sdtl_pkg::wrap_before(fnew_ff, now_ff);
            prev_in  = SlotEnd;
            cur_in   = head_ff;
            rd_addr  = head_ff[AddrW-1:0];
            state_in = (head_ff == SlotEnd) ? sdtl_pkg::ST_INS_LINK
                                            : sdtl_pkg::ST_INS_WALK;
         end

         // Advance past every entry that fires no later than the new one
         sdtl_pkg::ST_INS_WALK: begin
            if (goes_first) begin
               state_in = sdtl_pkg::ST_INS_LINK;
            end else begin
               prev_in = cur_ff;
               cur_in  = next_rd_ff;
               rd_addr = next_rd_ff[AddrW-1:0];
               if (next_rd_ff == SlotEnd) begin
                  state_in = sdtl_pkg::ST_INS_LINK;
               end
            end
         end

         sdtl_pkg::ST_INS_LINK: begin
            next_we = 1'b1;
            linked_in[slot_ff[AddrW-1:0]] = 1'b1;
            if (prev_ff == SlotEnd) begin
               head_in  = slot_ff;
               act_in   = sdtl_pkg::ACT_ARMED;
               rem_in   = sdtl_pkg::time_left(fnew_ff, now_ff);
               state_in = sdtl_pkg::ST_DONE;
            end else begin
               state_in = sdtl_pkg::ST_INS_PREV;
            end
         end

         sdtl_pkg::ST_INS_PREV: begin
            next_we  = 1'b1;
            next_wa  = prev_ff[AddrW-1:0];
            next_wd  = slot_ff;
            state_in = sdtl_pkg::ST_DONE;
         end

         // Hand the result over once the output register is free
         sdtl_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {1'b0, rem_ff, act_ff, fid_ff, fired_ff};
               state_in     = sdtl_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = sdtl_pkg::ST_IDLE;
         end
      endcase
   end

   // A head that is not the end mark points at a linked slot
   assert property (@(posedge clock) disable iff (reset)
      head_ff != SlotEnd |-> linked_ff[head_ff[AddrW-1:0]])
      else $error("head slot is not linked");

   // The head is a slot or the end mark
   assert property (@(posedge clock) disable iff (reset)
      head_ff <= SlotEnd)
      else $error("head slot out of range");

   // A fired timer always comes with an alarm update
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |-> rsp_tdata[6:5] != sdtl_pkg::ACT_NONE)
      else $error("fired without alarm update");

   // A taken request closes the input until its work is done
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while busy");

endmodule

/* tb/sorted_deadline_timer_list_tb.sv */
`timescale 1ns / 1ps

module sorted_deadline_timer_list_tb;

   localparam int SLOTS = 16;
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_CYCLES = 50;
   localparam int HOLD_CYCLES = 300;

   typedef struct packed {
      logic        fired;
      logic [3:0]  fired_id;
      logic [1:0]  action;
      logic [31:0] remaining;
   } alarm_rsp_type;

   typedef struct packed {
      logic [1:0]    op;
      logic [3:0]    id;
      logic [31:0]   t_now;
      logic [31:0]   t_base;
      logic [30:0]   dly;
      bit            typed;
      alarm_rsp_type rsp;
   } stim_row_type;

   localparam alarm_rsp_type RSP_ZERO = '0;

   logic                          clock;
   logic                          reset;
   logic                          req_tvalid;
   logic                          req_tready;
   logic [1:0]                    req_tuser;  // op
   // timer_id[3:0], now[35:4], start_time[67:36], delay[98:68], zero fill
   logic [sdtl_pkg::ReqDataW-1:0] req_tdata;
   logic                          rsp_tvalid;
   logic                          rsp_tready;
   // fired[0], fired_id[4:1], alarm_action[6:5], alarm_remaining[38:7], zero fill
   logic [sdtl_pkg::RspDataW-1:0] rsp_tdata;

   // Mirror of the timer list
   logic [31:0] slot_fire [SLOTS];
   bit          slot_linked [SLOTS];
   int          slot_link [SLOTS];
   int          list_head;
   logic [1:0]  alarm_code;
   logic [31:0] alarm_left;

   alarm_rsp_type alarm_expect_q [$];
   stim_row_type  directed_q [$];

   // Typed expectation for the request on the bus, if any
   bit            fixed_valid;
   alarm_rsp_type fixed_rsp;

   bit          tx_quiet;
   bit          rx_quiet;
   bit          hold_request;
   int          fail_count;
   int          cycle_count;
   logic [31:0] wall_now;

   sorted_deadline_timer_list #(
      .NUM_TIMERS(SLOTS)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   // a lies before b on the wrapping time line
   function automatic bit ring_earlier(input logic [31:0] a, input logic [31:0] b);
      logic [31:0] diff;
      diff = a - b;
      return diff[31];
   endfunction

   function automatic void refresh_alarm(input logic [31:0] t_now);
      if (list_head >= SLOTS) begin
         alarm_code = sdtl_pkg::ACT_STOPPED;
         alarm_left = 32'd0;
      end else begin
         alarm_code = sdtl_pkg::ACT_ARMED;
         alarm_left = ring_earlier(t_now, slot_fire[list_head]) ?
                      slot_fire[list_head] - t_now : 32'd0;
      end
   endfunction

   // Past deadlines go first, then wrap-aware order
   function automatic bit fires_ahead(input logic [31:0] a, input logic [31:0] b,
                                      input logic [31:0] t_now);
      bit a_past;
      a_past = ring_earlier(a, t_now);
      if (ring_earlier(b, t_now) != a_past)
         return a_past;
      return ring_earlier(a, b);
   endfunction

   function automatic void drop_slot(input int s, input logic [31:0] t_now);
      int  cur;
      int  steps;
      bit  found;
      if (!slot_linked[s])
         return;
      if (list_head == s) begin
         list_head = slot_link[s];
         refresh_alarm(t_now);
      end else begin
         cur = list_head;
         steps = 0;
         found = 0;
         while (steps < SLOTS && cur < SLOTS && !found) begin
            if (slot_link[cur] == s) begin
               slot_link[cur] = slot_link[s];
               found = 1;
            end else begin
               cur = slot_link[cur];
               steps++;
            end
         end
      end
      slot_linked[s] = 0;
   endfunction

   function automatic void place_slot(input int s, input logic [31:0] t_now);
      int prev;
      int cur;
      int steps;
      bit found;
      prev = SLOTS;
      cur = list_head;
      steps = 0;
      found = 0;
      while (steps < SLOTS && cur < SLOTS && !found) begin
         if (fires_ahead(slot_fire[s], slot_fire[cur], t_now)) begin
            found = 1;
         end else begin
            prev = cur;
            cur = slot_link[cur];
            steps++;
         end
      end
      if (cur >= SLOTS)
         cur = SLOTS;
      slot_link[s] = cur;
      slot_linked[s] = 1;
      if (prev >= SLOTS) begin
         list_head = s;
         refresh_alarm(t_now);
      end else begin
         slot_link[prev] = s;
      end
   endfunction

   // Apply one request to the mirror and return the alarm response it causes
   function automatic alarm_rsp_type timer_list_step(input logic [1:0] op,
                                                     input logic [3:0] id,
                                                     input logic [31:0] t_now,
                                                     input logic [31:0] t_base,
                                                     input logic [30:0] dly);
      alarm_rsp_type r;
      int            h;
      r = RSP_ZERO;
      alarm_code = sdtl_pkg::ACT_NONE;
      alarm_left = 32'd0;
      case (op)
         sdtl_pkg::OP_START: begin
            slot_fire[id] = t_base + {1'b0, dly};
            drop_slot(int'(id), t_now);
            place_slot(int'(id), t_now);
         end
         sdtl_pkg::OP_STOP: begin
            drop_slot(int'(id), t_now);
         end
         sdtl_pkg::OP_EXPIRE: begin
            h = list_head;
            if (h < SLOTS && !ring_earlier(t_now, slot_fire[h])) begin
               r.fired = 1'b1;
               r.fired_id = h[3:0];
               drop_slot(h, t_now);
            end else begin
               refresh_alarm(t_now);
            end
         end
         default: ;
      endcase
      r.action = alarm_code;
      r.remaining = alarm_left;
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("[%0t] MISMATCH %s", $realtime, msg);
      fail_count++;
   endtask

   function automatic alarm_rsp_type rsp_of(input logic f, input logic [3:0] fid,
                                            input logic [1:0] act, input logic [31:0] rem);
      alarm_rsp_type r;
      r.fired = f;
      r.fired_id = fid;
      r.action = act;
      r.remaining = rem;
      return r;
   endfunction

   function automatic void add_row(input logic [1:0] op, input logic [3:0] id,
                                   input logic [31:0] t_now, input logic [31:0] t_base,
                                   input logic [30:0] dly, input bit typed,
                                   input alarm_rsp_type rsp);
      stim_row_type row;
      row.op = op;
      row.id = id;
      row.t_now = t_now;
      row.t_base = t_base;
      row.dly = dly;
      row.typed = typed;
      row.rsp = rsp;
      directed_q.push_back(row);
   endfunction

   // Track accepted requests, then check accepted responses against the oldest one
   always @(posedge clock) begin
      alarm_rsp_type want;
      alarm_rsp_type got;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            want = timer_list_step(req_tuser, req_tdata[3:0], req_tdata[35:4],
                                   req_tdata[67:36], req_tdata[98:68]);
            alarm_expect_q.push_back(fixed_valid ? fixed_rsp : want);
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_of(rsp_tdata[0], rsp_tdata[4:1], rsp_tdata[6:5], rsp_tdata[38:7]);
            if (alarm_expect_q.size() == 0) begin
               report_mismatch($sformatf("response with nothing outstanding: %h", rsp_tdata));
            end else begin
               want = alarm_expect_q.pop_front();
               if (got.fired !== want.fired)
                  report_mismatch($sformatf("fired %b, want %b", got.fired, want.fired));
               if (got.fired_id !== want.fired_id)
                  report_mismatch($sformatf("fired_id %0d, want %0d",
                                            got.fired_id, want.fired_id));
               if (got.action !== want.action)
                  report_mismatch($sformatf("alarm_action %0d, want %0d",
                                            got.action, want.action));
               if (got.remaining !== want.remaining)
                  report_mismatch($sformatf("alarm_remaining %h, want %h",
                                            got.remaining, want.remaining));
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // Response side: random back-pressure bursts, one long hold-off on request
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else if (!rx_quiet && $urandom_range(0, 4) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 8) - 1) @(negedge clock);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Offer one request; entered and left at a falling edge
   task automatic send_request(input logic [1:0] op, input logic [3:0] id,
                               input logic [31:0] t_now, input logic [31:0] t_base,
                               input logic [30:0] dly, input bit typed,
                               input alarm_rsp_type rsp);
      int gap;
      gap = (!tx_quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      fixed_valid = typed;
      fixed_rsp = rsp;
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {5'd0, dly, t_base, t_now, id};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // Random requests around a drifting clock; unused ops do not count
   task automatic run_random(input int count);
      int          done;
      int          pick;
      logic [1:0]  op;
      logic [31:0] t_base;
      logic [30:0] dly;
      done = 0;
      while (done < count) begin
         pick = $urandom_range(0, 99);
         op = (pick < 42) ? sdtl_pkg::OP_START : (pick < 60) ? sdtl_pkg::OP_STOP :
              (pick < 95) ? sdtl_pkg::OP_EXPIRE : OP_UNUSED;
         // advance time mostly in small steps, now and then jump anywhere
         if ($urandom_range(0, 19) == 0)
            wall_now = $urandom;
         else
            wall_now = wall_now + $urandom_range(0, 300);
         t_base = ($urandom_range(0, 4) == 0) ? $urandom : wall_now;
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: dly = 31'($urandom_range(0, 600));
            6, 7:             dly = 31'($urandom_range(0, 100000));
            8:                dly = 31'($urandom);
            default:          dly = $urandom_range(0, 1) ? 31'h7FFF_FFFF : 31'd0;
         endcase
         send_request(op, 4'($urandom_range(0, SLOTS - 1)), wall_now, t_base, dly,
                      1'b0, RSP_ZERO);
         if (op != OP_UNUSED)
            done++;
      end
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tuser = '0;
      req_tdata = '0;
      fixed_valid = 0;
      fixed_rsp = RSP_ZERO;
      tx_quiet = 0;
      rx_quiet = 0;
      hold_request = 0;
      fail_count = 0;
      cycle_count = 0;
      wall_now = 32'd0;
      for (int i = 0; i < SLOTS; i++) begin
         slot_fire[i] = '0;
         slot_linked[i] = 0;
         slot_link[i] = 0;
      end
      list_head = SLOTS;

      // Empty list, ignored op, idle stop, first arm
      add_row(sdtl_pkg::OP_EXPIRE, 4'd0, 32'd0, 32'd0, 31'd0, 1'b1,
              rsp_of(1'b0, 4'd0, sdtl_pkg::ACT_STOPPED, 32'd0));
      add_row(OP_UNUSED, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 1'b1, RSP_ZERO);
      add_row(sdtl_pkg::OP_STOP, 4'd5, 32'd0, 32'd0, 31'd0, 1'b1, RSP_ZERO);
      add_row(sdtl_pkg::OP_START, 4'd0, 32'd0, 32'd0, 31'd100, 1'b1,
              rsp_of(1'b0, 4'd0, sdtl_pkg::ACT_ARMED, 32'd100));
      // Maximum delay wrapping past zero, new head, tie, restart of the head
      add_row(sdtl_pkg::OP_START, 4'd15, 32'd0, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 1'b0, RSP_ZERO);
      add_row(sdtl_pkg::OP_START, 4'd3, 32'd0, 32'd50, 31'd0, 1'b0, RSP_ZERO);
      add_row(sdtl_pkg::OP_START, 4'd7, 32'd0, 32'd40, 31'd10, 1'b0, RSP_ZERO);
      add_row(sdtl_pkg::OP_START, 4'd3, 32'd0, 32'd0, 31'd200, 1'b0, RSP_ZERO);
      // Unexpired head, then expiry
      add_row(sdtl_pkg::OP_EXPIRE, 4'd0, 32'd49, 32'd0, 31'd0, 1'b0, RSP_ZERO);
      add_row(sdtl_pkg::OP_EXPIRE, 4'd0, 32'd50, 32'd0, 31'd0, 1'b0, RSP_ZERO);
      // Deadline already past goes to the front
      add_row(sdtl_pkg::OP_START, 4'd1, 32'd1000, 32'd0, 31'd10, 1'b0, RSP_ZERO);
      add_row(sdtl_pkg::OP_EXPIRE, 4'd0, 32'd1000, 32'd0, 31'd0, 1'b0, RSP_ZERO);
      // Stop the tail, the head, then an unlinked slot
      add_row(sdtl_pkg::OP_STOP, 4'd15, 32'd1000, 32'd0, 31'd0, 1'b0, RSP_ZERO);
      add_row(sdtl_pkg::OP_STOP, 4'd0, 32'd1000, 32'd0, 31'd0, 1'b0, RSP_ZERO);
      add_row(sdtl_pkg::OP_STOP, 4'd0, 32'd1000, 32'd0, 31'd0, 1'b1, RSP_ZERO);
      // Fire times across the wrap of the time counter
      add_row(sdtl_pkg::OP_START, 4'd2, 32'hFFFF_FFF0, 32'hFFFF_FFF0, 31'd20, 1'b0, RSP_ZERO);
      add_row(sdtl_pkg::OP_START, 4'd4, 32'hFFFF_FFF0, 32'hFFFF_FFF0, 31'd0, 1'b0, RSP_ZERO);
      add_row(sdtl_pkg::OP_EXPIRE, 4'd0, 32'hFFFF_FFFF, 32'd0, 31'd0, 1'b0, RSP_ZERO);
      add_row(sdtl_pkg::OP_EXPIRE, 4'd0, 32'd4, 32'd0, 31'd0, 1'b0, RSP_ZERO);
      add_row(sdtl_pkg::OP_STOP, 4'd3, 32'd4, 32'd0, 31'd0, 1'b0, RSP_ZERO);
      add_row(sdtl_pkg::OP_EXPIRE, 4'd0, 32'd4, 32'd0, 31'd0, 1'b0, RSP_ZERO);
      add_row(sdtl_pkg::OP_START, 4'd9, 32'd0, 32'd0, 31'h7FFF_FFFF, 1'b0, RSP_ZERO);
      add_row(sdtl_pkg::OP_START, 4'd8, 32'd0, 32'd0, 31'd0, 1'b0, RSP_ZERO);
      add_row(OP_UNUSED, 4'd0, 32'd0, 32'd0, 31'd0, 1'b1, RSP_ZERO);

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_q[i])
         send_request(directed_q[i].op, directed_q[i].id, directed_q[i].t_now,
                      directed_q[i].t_base, directed_q[i].dly, directed_q[i].typed,
                      directed_q[i].rsp);

      run_random(180);

      // Hold the response side off while requests keep coming back to back
      tx_quiet = 1;
      hold_request = 1;
      run_random(24);
      tx_quiet = 0;

      run_random(120);

      // Closing stretch without idling
      tx_quiet = 1;
      rx_quiet = 1;
      run_random(86);
      req_tvalid <= 1'b0;

      while (alarm_expect_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
